FILE: hw/rtl/slps_pkg.sv
// ----------------------------------------------------------------------------
// slps_pkg - shared types and constants for the status LED pattern sequencer
// Command and LED payload structs, command and mode codes, fixed pattern
// timings and the breathing level scale.
// ----------------------------------------------------------------------------
package slps_pkg;

    // Command payload: one event per transaction
    typedef struct packed {
        logic [2:0] opcode;
        logic [3:0] device_mode;
        logic       flag_value;
    } cmd_t;

    // LED payload: one result per transaction
    typedef struct packed {
        logic [7:0] green_duty;
        logic       red_on;
        logic       blue_on;
    } led_t;

    // Opcodes
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_STATE   = 3'd1;
    localparam logic [2:0] OP_PRESSED = 3'd2;
    localparam logic [2:0] OP_LINK    = 3'd3;
    localparam logic [2:0] OP_TRIM    = 3'd4;

    // Device modes
    localparam logic [3:0] MODE_BOOT        = 4'd0;
    localparam logic [3:0] MODE_CONNECTING  = 4'd1;
    localparam logic [3:0] MODE_IDLE        = 4'd2;
    localparam logic [3:0] MODE_CHECKING    = 4'd3;
    localparam logic [3:0] MODE_RECORDING   = 4'd4;
    localparam logic [3:0] MODE_PROCESSING  = 4'd5;
    localparam logic [3:0] MODE_UPLOADING   = 4'd6;
    localparam logic [3:0] MODE_DOWNLOADING = 4'd7;
    localparam logic [3:0] MODE_PLAYING     = 4'd8;
    localparam logic [3:0] MODE_ERROR       = 4'd9;
    localparam logic [3:0] MODE_OTHER       = 4'd10;

    // Configuration register indexes
    localparam logic [1:0] CFG_FAST_PULSE = 2'd0;
    localparam logic [1:0] CFG_PULSE_OFF  = 2'd1;
    localparam logic [1:0] CFG_TRIM_BLINK = 2'd2;

    localparam int unsigned CFG_W = 12;

    localparam logic [CFG_W-1:0] FAST_PULSE_RST = 12'd50;
    localparam logic [CFG_W-1:0] PULSE_OFF_RST  = 12'd180;
    localparam logic [CFG_W-1:0] TRIM_BLINK_RST = 12'd400;

    // Breathing level scale
    localparam logic [7:0]  FULL_DUTY    = 8'd255;
    localparam logic [7:0]  BREATHE_BASE = 8'd32;
    localparam logic [63:0] BREATHE_SPAN = 64'd223;
    localparam logic [63:0] PI_Q60       = 64'h3243F6A8885A308D;

    // Wifi-lost flash: phases of 150/150/150/700 ms
    function automatic logic [CFG_W-1:0] link_phase_ms(input logic [1:0] phase);
        logic [CFG_W-1:0] ms;
        ms = (phase == 2'd3) ? 12'd700 : 12'd150;
        return ms;
    endfunction

    // Upload pulse on times
    function automatic logic [CFG_W-1:0] up_on_ms(input logic [1:0] idx);
        logic [CFG_W-1:0] ms;
        case (idx)
            2'd0:    ms = 12'd100;
            2'd1:    ms = 12'd300;
            default: ms = 12'd600;
        endcase
        return ms;
    endfunction

    // Download pulse on times
    function automatic logic [CFG_W-1:0] down_on_ms(input logic [1:0] idx);
        logic [CFG_W-1:0] ms;
        case (idx)
            2'd0:    ms = 12'd600;
            2'd1:    ms = 12'd300;
            default: ms = 12'd100;
        endcase
        return ms;
    endfunction

    function automatic led_t led_val(input logic [7:0] g, input logic r, input logic b);
        led_t v;
        v.green_duty = g;
        v.red_on     = r;
        v.blue_on    = b;
        return v;
    endfunction

endpackage

FILE: hw/rtl/status_led_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// status_led_pattern_sequencer - status LED pattern generator
// Turns device events into green PWM duty and red/blue on/off levels.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid/cmd_stall/cmd) carries one event per transaction:
//   a 1 ms tick, a state update, a pressed hint, a wifi flag or a trim hint.
//   led channel (led_valid/led_stall/led) returns exactly one transaction per
//   event: the LED levels after that event.
//   led_valid rises in the cycle after acceptance. One event is taken every
//   cycle while cmd_stall is low; the state and the output registers load
//   together, and the breathing level comes from a ROM whose two read ports
//   are registered ahead of time from the next breathing position.
//   While led_stall holds a waiting result, cmd_stall is raised; when the
//   result is taken in the same cycle, a new event is still accepted.
//   The config port (cfg_we/cfg_index/cfg_data) writes the three timing
//   registers; index 3 is ignored. Write only while no event is in flight.
//   Reset brings boot mode with all LEDs dark until an event re-evaluates
//   the pattern, link up, all counters at zero and the timing registers at
//   50/180/400 ms.
// ----------------------------------------------------------------------------
module status_led_pattern_sequencer
    import slps_pkg::*;
#(
    parameter int BREATHE_PERIOD = 1800,
    parameter int ELAPSED_WIDTH  = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  cmd_t             cmd,
    output logic             led_valid,
    input  logic             led_stall,
    output led_t             led,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int POS_W = $clog2(BREATHE_PERIOD);
    localparam int EW    = ELAPSED_WIDTH;
    localparam int CMP_W = (EW > CFG_W) ? EW : CFG_W;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(BREATHE_PERIOD - 1);

    // Configuration
    logic [CFG_W-1:0] fast_pulse_reg;
    logic [CFG_W-1:0] pulse_off_reg;
    logic [CFG_W-1:0] trim_blink_reg;

    // Pattern state
    logic [3:0]       mode_reg,          mode_next;
    logic             pending_reg,       pending_next;
    logic             pressed_reg,       pressed_next;
    logic             trim_reg,          trim_next;
    logic             link_up_reg,       link_up_next;
    logic             blink_lit_reg,     blink_lit_next;
    logic [1:0]       pulse_index_reg,   pulse_index_next;
    logic [1:0]       link_phase_reg,    link_phase_next;
    logic [EW-1:0]    blink_elapsed_reg, blink_elapsed_next;
    logic [EW-1:0]    link_elapsed_reg,  link_elapsed_next;
    logic [POS_W-1:0] breathe_pos_reg,   breathe_pos_next;
    led_t             led_reg,           led_next;
    logic             led_valid_reg,     led_valid_next;

    logic             cmd_acc;
    logic [7:0]       cur_level;
    logic [7:0]       nxt_level;

    function automatic logic link_on(input logic [3:0] mode, input logic up);
        return !up && (mode == MODE_IDLE || mode == MODE_CHECKING ||
                       mode == MODE_ERROR || mode >= MODE_OTHER);
    endfunction

    function automatic led_t apply_pattern(
        input logic [3:0] mode,
        input logic       lnk,
        input logic [1:0] phase,
        input logic       lit,
        input logic       trim,
        input logic       pending,
        input logic       pressed,
        input logic [7:0] level
    );
        led_t r;
        r = led_val(8'd0, 1'b0, 1'b0);
        if (lnk)
        begin
            if (phase == 2'd0 || phase == 2'd2)
            begin
                r = led_val(FULL_DUTY, 1'b1, 1'b0);
            end
        end
        else
        begin
            unique case (mode) inside
                MODE_BOOT:       r = led_val(FULL_DUTY, 1'b1, 1'b1);
                MODE_CONNECTING: r = led_val(FULL_DUTY, 1'b1, 1'b0);
                MODE_RECORDING:  r = led_val(FULL_DUTY, 1'b0, 1'b1);
                MODE_PROCESSING,
                MODE_UPLOADING:
                begin
                    if (lit) r = led_val(FULL_DUTY, 1'b0, 1'b0);
                end
                MODE_DOWNLOADING:
                begin
                    if (lit) r = led_val(FULL_DUTY, 1'b0, 1'b1);
                end
                MODE_PLAYING:
                begin
                    if (!trim || lit) r = led_val(FULL_DUTY, 1'b0, 1'b0);
                end
                MODE_ERROR:      r = led_val(8'd0, 1'b1, 1'b0);
                default:
                begin
                    if (pending)      r = led_val(level, 1'b0, 1'b0);
                    else if (pressed) r = led_val(FULL_DUTY, 1'b0, 1'b0);
                end
            endcase
        end
        return r;
    endfunction

    function automatic logic [CFG_W-1:0] pulse_step(
        input logic [3:0]       mode,
        input logic             lit,
        input logic [1:0]       idx,
        input logic             trim,
        input logic [CFG_W-1:0] fast,
        input logic [CFG_W-1:0] off,
        input logic [CFG_W-1:0] trim_ms
    );
        logic [CFG_W-1:0] s;
        unique case (mode)
            MODE_PROCESSING:  s = fast;
            MODE_UPLOADING:   s = lit ? up_on_ms(idx) : off;
            MODE_DOWNLOADING: s = lit ? down_on_ms(idx) : off;
            MODE_PLAYING:     s = trim ? trim_ms : '0;
            default:          s = '0;
        endcase
        return s;
    endfunction

    // Handshake: accept when the result register is empty or being drained
    assign cmd_stall = led_valid_reg && led_stall;
    assign cmd_acc   = cmd_valid && !cmd_stall;

    slps_breathe_rom #(
        .BREATHE_PERIOD(BREATHE_PERIOD),
        .POS_W         (POS_W)
    ) u_rom (
        .clk      (clk),
        .rst_n    (rst_n),
        .addr     (breathe_pos_next),
        .cur_level(cur_level),
        .nxt_level(nxt_level)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_pulse_reg <= FAST_PULSE_RST;
            pulse_off_reg  <= PULSE_OFF_RST;
            trim_blink_reg <= TRIM_BLINK_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FAST_PULSE: fast_pulse_reg <= cfg_data;
                CFG_PULSE_OFF:  pulse_off_reg  <= cfg_data;
                CFG_TRIM_BLINK: trim_blink_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        logic             do_apply;
        logic [7:0]       level;
        logic [CFG_W-1:0] step;

        mode_next          = mode_reg;
        pending_next       = pending_reg;
        pressed_next       = pressed_reg;
        trim_next          = trim_reg;
        link_up_next       = link_up_reg;
        blink_lit_next     = blink_lit_reg;
        pulse_index_next   = pulse_index_reg;
        link_phase_next    = link_phase_reg;
        blink_elapsed_next = blink_elapsed_reg;
        link_elapsed_next  = link_elapsed_reg;
        breathe_pos_next   = breathe_pos_reg;
        led_next           = led_reg;
        do_apply           = 1'b0;
        level              = cur_level;
        step               = '0;

        if (cmd_acc)
        begin
            unique case (cmd.opcode)
                OP_TICK:
                begin
                    // Advance position and saturating counters, then check timers
                    level              = nxt_level;
                    breathe_pos_next   = (breathe_pos_reg == LAST_POS) ? '0
                                         : breathe_pos_reg + 1'b1;
                    blink_elapsed_next = (&blink_elapsed_reg) ? blink_elapsed_reg
                                         : blink_elapsed_reg + 1'b1;
                    link_elapsed_next  = (&link_elapsed_reg) ? link_elapsed_reg
                                         : link_elapsed_reg + 1'b1;
                    step = pulse_step(mode_reg, blink_lit_reg, pulse_index_reg,
                                      trim_reg, fast_pulse_reg, pulse_off_reg,
                                      trim_blink_reg);
                    if (link_on(mode_reg, link_up_reg))
                    begin
                        if (CMP_W'(link_elapsed_next) >=
                            CMP_W'(link_phase_ms(link_phase_reg)))
                        begin
                            link_elapsed_next = '0;
                            link_phase_next   = link_phase_reg + 1'b1;
                            do_apply          = 1'b1;
                        end
                    end
                    else if (pending_reg &&
                             (mode_reg == MODE_IDLE || mode_reg == MODE_CHECKING))
                    begin
                        do_apply = 1'b1;
                    end
                    else if (step != '0 && CMP_W'(blink_elapsed_next) >= CMP_W'(step))
                    begin
                        blink_elapsed_next = '0;
                        if (blink_lit_reg)
                        begin
                            pulse_index_next = (pulse_index_reg == 2'd2) ? 2'd0
                                               : pulse_index_reg + 1'b1;
                        end
                        blink_lit_next = !blink_lit_reg;
                        do_apply       = 1'b1;
                    end
                end
                OP_STATE:
                begin
                    if (cmd.device_mode != mode_reg)
                    begin
                        blink_elapsed_next = '0;
                        pulse_index_next   = 2'd0;
                        blink_lit_next     = (cmd.device_mode != MODE_PROCESSING);
                    end
                    mode_next    = cmd.device_mode;
                    pending_next = cmd.flag_value;
                    do_apply     = 1'b1;
                end
                OP_PRESSED:
                begin
                    pressed_next = cmd.flag_value;
                    do_apply     = 1'b1;
                end
                OP_LINK:
                begin
                    if (link_up_reg != cmd.flag_value)
                    begin
                        link_up_next      = cmd.flag_value;
                        link_phase_next   = 2'd0;
                        link_elapsed_next = '0;
                        do_apply          = 1'b1;
                    end
                end
                OP_TRIM:
                begin
                    if (trim_reg != cmd.flag_value)
                    begin
                        trim_next          = cmd.flag_value;
                        blink_elapsed_next = '0;
                        blink_lit_next     = 1'b1;
                        do_apply           = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (do_apply)
        begin
            led_next = apply_pattern(mode_next, link_on(mode_next, link_up_next),
                                     link_phase_next, blink_lit_next, trim_next,
                                     pending_next, pressed_next, level);
        end

        // Hold a stalled result, drop it once taken
        if (cmd_acc)
        begin
            led_valid_next = 1'b1;
        end
        else
        begin
            led_valid_next = led_valid_reg && led_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_BOOT;
            pending_reg       <= 1'b0;
            pressed_reg       <= 1'b0;
            trim_reg          <= 1'b0;
            link_up_reg       <= 1'b1;
            blink_lit_reg     <= 1'b0;
            pulse_index_reg   <= 2'd0;
            link_phase_reg    <= 2'd0;
            blink_elapsed_reg <= '0;
            link_elapsed_reg  <= '0;
            breathe_pos_reg   <= '0;
            led_reg           <= led_val(8'd0, 1'b0, 1'b0);
            led_valid_reg     <= 1'b0;
        end
        else
        begin
            mode_reg          <= mode_next;
            pending_reg       <= pending_next;
            pressed_reg       <= pressed_next;
            trim_reg          <= trim_next;
            link_up_reg       <= link_up_next;
            blink_lit_reg     <= blink_lit_next;
            pulse_index_reg   <= pulse_index_next;
            link_phase_reg    <= link_phase_next;
            blink_elapsed_reg <= blink_elapsed_next;
            link_elapsed_reg  <= link_elapsed_next;
            breathe_pos_reg   <= breathe_pos_next;
            led_reg           <= led_next;
            led_valid_reg     <= led_valid_next;
        end
    end

    assign led_valid = led_valid_reg;
    assign led       = led_reg;

    // Assertions
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        breathe_pos_reg <= LAST_POS)
        else $error("breathing position out of range");

    a_pulse_index: assert property (@(posedge clk) disable iff (!rst_n)
        pulse_index_reg != 2'd3)
        else $error("pulse index out of range");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_acc |=> led_valid_reg)
        else $error("accepted command produced no result");

    a_no_accept_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (led_valid_reg && led_stall) |-> !cmd_acc)
        else $error("command accepted over a waiting result");

    a_trim_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_acc && cmd.opcode == OP_TRIM && cmd.flag_value != trim_reg)
        |=> (blink_lit_reg && blink_elapsed_reg == '0))
        else $error("trim change did not restart the blink");

endmodule

FILE: hw/rtl/slps_breathe_rom.sv
// ----------------------------------------------------------------------------
// slps_breathe_rom - breathing green level table
// One entry per millisecond of the breathing period, filled at elaboration
// with 32 + 223*sin^2(pi*k/period), computed in Q60 fixed point. Two registered reads:
// the level at the given position and at the position after it.
// ----------------------------------------------------------------------------
module slps_breathe_rom
    import slps_pkg::*;
#(
    parameter int BREATHE_PERIOD = 1800,
    parameter int POS_W          = 11
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [POS_W-1:0] addr,
    output logic [7:0]       cur_level,
    output logic [7:0]       nxt_level
);

    typedef logic [7:0] rom_t [BREATHE_PERIOD];

    // Angle step per position: whole part and remainder of pi over the period
    localparam logic [63:0] PI_STEP = PI_Q60 / 64'(BREATHE_PERIOD);
    localparam logic [63:0] PI_REM  = PI_Q60 % 64'(BREATHE_PERIOD);

    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // Truncating quotient by shift and subtract, used only to build the table
    function automatic logic [63:0] quo64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [7:0] level_at(input int unsigned p);
        logic [63:0] k;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] s2;
        logic [63:0] part;
        logic [63:0] dvsr;
        if (2 * p == BREATHE_PERIOD)
        begin
            return FULL_DUTY;
        end
        k = (p <= BREATHE_PERIOD - p) ? 64'(p) : 64'(BREATHE_PERIOD - p);
        x = PI_STEP * k + quo64(PI_REM * k, 64'(BREATHE_PERIOD));
        x2   = mul_q60(x, x);
        term = x;
        sum  = x;
        // Taylor series up to the x^27 term, every step truncating
        for (int n = 3; n <= 27; n += 2)
        begin
            dvsr = 64'((n - 1) * n);
            term = quo64(mul_q60(term, x2), dvsr);
            if (((n >> 1) & 1) != 0)
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        s2   = mul_q60(sum, sum);
        part = (((s2 >> 32) * BREATHE_SPAN)
               + (((s2 & 64'hFFFF_FFFF) * BREATHE_SPAN) >> 32)) >> 28;
        if (part > BREATHE_SPAN)
        begin
            part = BREATHE_SPAN;
        end
        return BREATHE_BASE + part[7:0];
    endfunction

    function automatic rom_t build_rom();
        rom_t r;
        for (int i = 0; i < BREATHE_PERIOD; i++)
        begin
            r[i] = level_at(i);
        end
        return r;
    endfunction

    localparam rom_t LEVEL_ROM = build_rom();
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(BREATHE_PERIOD - 1);

    logic [POS_W-1:0] addr_nxt;
    logic [7:0]       cur_level_reg;
    logic [7:0]       nxt_level_reg;

    assign addr_nxt = (addr == LAST_POS) ? '0 : addr + 1'b1;

    // Reset loads the entries for position zero so the outputs track the
    // position register from the first cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_level_reg <= LEVEL_ROM[0];
            nxt_level_reg <= LEVEL_ROM[1];
        end
        else
        begin
            cur_level_reg <= LEVEL_ROM[addr];
            nxt_level_reg <= LEVEL_ROM[addr_nxt];
        end
    end

    assign cur_level = cur_level_reg;
    assign nxt_level = nxt_level_reg;

endmodule
